// ----- rtl/core/lpm_pkg.sv -----
// Shared constants for the load protection monitor: field widths, register
// indexes, reset values and flag bit positions.
// No dependencies.
`default_nettype none

package lpm_pkg;

    // Width of the tick-age counter of the link watchdog
    localparam int AGE_BITS = 16;

    // Field widths
    localparam int VOLT_W  = 16;
    localparam int CURR_W  = 16;
    localparam int POWER_W = 32;
    localparam int TEMP_W  = 12;
    localparam int HYST_W  = 10;
    localparam int TOUT_W  = 16;
    localparam int FLAG_W  = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OV_LIMIT  = 3'd0,
        REG_OC_LIMIT  = 3'd1,
        REG_OP_LIMIT  = 3'd2,
        REG_OT_TRIP   = 3'd3,
        REG_OT_WARN   = 3'd4,
        REG_OT_HYST   = 3'd5,
        REG_LINK_TOUT = 3'd6
    } t_reg_idx;

    // Register reset values
    localparam logic [VOLT_W-1:0]         OV_LIMIT_RST  = 16'd15000;
    localparam logic [CURR_W-1:0]         OC_LIMIT_RST  = 16'd11000;
    localparam logic [POWER_W-1:0]        OP_LIMIT_RST  = 32'd10500000;
    localparam logic signed [TEMP_W-1:0]  OT_TRIP_RST   = 12'sd900;
    localparam logic signed [TEMP_W-1:0]  OT_WARN_RST   = 12'sd750;
    localparam logic [HYST_W-1:0]         OT_HYST_RST   = 10'd100;
    localparam logic [TOUT_W-1:0]         LINK_TOUT_RST = 16'd500;

    // Flag bit positions
    localparam int FLAG_OV   = 0;
    localparam int FLAG_OC   = 1;
    localparam int FLAG_OP   = 2;
    localparam int FLAG_OT   = 3;
    localparam int FLAG_LINK = 4;

    // Item kind carried in the input tuser
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_PING = 1'b1
    } t_cmd;

    // Packed stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

endpackage

`default_nettype wire

// ----- rtl/core/load_protection_monitor_top.sv -----
// Load protection monitor top level: input register, protection decision
// logic with its state, result register, configuration registers.
// Depends on lpm_pkg.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata: hw_trip, voltage, current, temp
//                                        tuser: cmd
// m_axis    out  m_axis_tvalid/tready    tdata: flags, in_fault, force_off,
//                                               fault_led, load_power
// cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle sustained; each item passes from acceptance through the
// input register, then one multiply and compare pass, into the result
// register. Protection state updates as the result is registered.
// Synchronous active-low reset clears state and valid bits, presets limits.
// A stalled result keeps the input register full until it drains; the
// input side stays ready whenever the decision stage can advance.
`default_nettype none

module load_protection_monitor_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] hw_trip, [16:1] load_voltage, [32:17] load_current,
    // [44:33] heatsink_temp, [47:45] zero
    input  wire logic [lpm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  wire logic                          s_axis_tuser,
    // result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [4:0] flags, [5] in_fault, [6] force_off, [7] fault_led,
    // [39:8] load_power
    output logic [lpm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = lpm_pkg::AGE_BITS;

    // Configuration registers
    logic [lpm_pkg::VOLT_W-1:0]         r_ov_limit;
    logic [lpm_pkg::CURR_W-1:0]         r_oc_limit;
    logic [lpm_pkg::POWER_W-1:0]        r_op_limit;
    logic signed [lpm_pkg::TEMP_W-1:0]  r_ot_trip;
    logic signed [lpm_pkg::TEMP_W-1:0]  r_ot_warn;
    logic [lpm_pkg::HYST_W-1:0]         r_ot_hyst;
    logic [lpm_pkg::TOUT_W-1:0]         r_link_tout;

    // Input register
    logic                               r_in_valid;
    logic                               r_cmd;
    logic                               r_hw_trip;
    logic [lpm_pkg::VOLT_W-1:0]         r_volt;
    logic [lpm_pkg::CURR_W-1:0]         r_curr;
    logic signed [lpm_pkg::TEMP_W-1:0]  r_temp;

    // Protection state
    logic [lpm_pkg::FLAG_W-1:0]         r_flags, n_flags;
    logic                               r_fault, n_fault;
    logic                               r_led, n_led;
    logic [AW-1:0]                      r_ticks, n_ticks;
    logic                               n_force;
    logic [lpm_pkg::POWER_W-1:0]        n_power;

    // Result register
    logic                               r_out_valid;
    logic [lpm_pkg::OUT_DATA_W-1:0]     r_out_data;

    logic                               s_accept;
    logic                               advance;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov_limit  <= lpm_pkg::OV_LIMIT_RST;
            r_oc_limit  <= lpm_pkg::OC_LIMIT_RST;
            r_op_limit  <= lpm_pkg::OP_LIMIT_RST;
            r_ot_trip   <= lpm_pkg::OT_TRIP_RST;
            r_ot_warn   <= lpm_pkg::OT_WARN_RST;
            r_ot_hyst   <= lpm_pkg::OT_HYST_RST;
            r_link_tout <= lpm_pkg::LINK_TOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (lpm_pkg::t_reg_idx'(i_cfg_index))
                lpm_pkg::REG_OV_LIMIT:  r_ov_limit  <= i_cfg_data[lpm_pkg::VOLT_W-1:0];
                lpm_pkg::REG_OC_LIMIT:  r_oc_limit  <= i_cfg_data[lpm_pkg::CURR_W-1:0];
                lpm_pkg::REG_OP_LIMIT:  r_op_limit  <= i_cfg_data[lpm_pkg::POWER_W-1:0];
                lpm_pkg::REG_OT_TRIP:   r_ot_trip   <= i_cfg_data[lpm_pkg::TEMP_W-1:0];
                lpm_pkg::REG_OT_WARN:   r_ot_warn   <= i_cfg_data[lpm_pkg::TEMP_W-1:0];
                lpm_pkg::REG_OT_HYST:   r_ot_hyst   <= i_cfg_data[lpm_pkg::HYST_W-1:0];
                lpm_pkg::REG_LINK_TOUT: r_link_tout <= i_cfg_data[lpm_pkg::TOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture input items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd     <= s_axis_tuser;
            r_hw_trip <= s_axis_tdata[0];
            r_volt    <= s_axis_tdata[16:1];
            r_curr    <= s_axis_tdata[32:17];
            r_temp    <= s_axis_tdata[44:33];
        end
    end

    // Judge the registered item against the limits
    always_comb begin
        logic                              stop;
        logic signed [lpm_pkg::TEMP_W:0]   t_clr;
        logic signed [lpm_pkg::TEMP_W:0]   t_ext;
        n_flags = r_flags;
        n_fault = r_fault;
        n_led   = r_led;
        n_ticks = r_ticks;
        n_force = 1'b0;
        n_power = '0;
        stop    = 1'b0;
        t_ext   = (lpm_pkg::TEMP_W+1)'(r_temp);
        t_clr   = (lpm_pkg::TEMP_W+1)'(r_ot_warn)
                - $signed({1'b0, 2'b00, r_ot_hyst});
        if (lpm_pkg::t_cmd'(r_cmd) == lpm_pkg::CMD_PING) begin
            n_ticks = '0;
        end else begin
            n_power = lpm_pkg::POWER_W'(r_volt) * lpm_pkg::POWER_W'(r_curr);
            if (r_ticks != {AW{1'b1}}) begin
                n_ticks = r_ticks + AW'(1);
            end
            // hardware trip overrides every software check
            if (r_hw_trip) begin
                n_flags[lpm_pkg::FLAG_OV] = 1'b1;
                n_flags[lpm_pkg::FLAG_OC] = 1'b1;
                n_led = 1'b1;
                stop  = 1'b1;
            end
            if (!stop) begin
                n_flags[lpm_pkg::FLAG_OV] = r_volt > r_ov_limit;
                stop = r_volt > r_ov_limit;
            end
            if (!stop) begin
                n_flags[lpm_pkg::FLAG_OC] = r_curr > r_oc_limit;
                stop = r_curr > r_oc_limit;
            end
            if (!stop) begin
                n_flags[lpm_pkg::FLAG_OP] = n_power > r_op_limit;
                stop = n_power > r_op_limit;
            end
            // temperature: trip, warn band with hysteresis
            if (!stop) begin
                if (r_temp > r_ot_trip) begin
                    n_flags[lpm_pkg::FLAG_OT] = 1'b1;
                    stop = 1'b1;
                end else if (r_temp > r_ot_warn) begin
                    n_flags[lpm_pkg::FLAG_OT] = 1'b1;
                end else if (t_ext < t_clr) begin
                    n_flags[lpm_pkg::FLAG_OT] = 1'b0;
                end
            end
            if (stop) begin
                n_fault = 1'b1;
                n_force = 1'b1;
            end else begin
                n_flags[lpm_pkg::FLAG_LINK] = 33'(n_ticks) > 33'(r_link_tout);
                // release the fault once every flag is clear
                if (n_flags == '0 && r_fault) begin
                    n_fault = 1'b0;
                    n_led   = 1'b0;
                end
            end
        end
    end

    // Advance state and result register together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_fault     <= 1'b0;
            r_led       <= 1'b0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_flags     <= n_flags;
                r_fault     <= n_fault;
                r_led       <= n_led;
                r_ticks     <= n_ticks;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {n_power, n_led, n_force, n_fault, n_flags};
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for load_protection_monitor_top: table-driven and random
// sample items are checked against typed table results or an in-bench model of the
// protection decisions. Depends on lpm_pkg and the load_protection_monitor_top RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpm_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // One flag bit per protection cause
    localparam logic [FLAG_W-1:0] FL_OV = FLAG_W'(1 << FLAG_OV);
    localparam logic [FLAG_W-1:0] FL_OC = FLAG_W'(1 << FLAG_OC);
    localparam logic [FLAG_W-1:0] FL_OP = FLAG_W'(1 << FLAG_OP);
    localparam logic [FLAG_W-1:0] FL_OT = FLAG_W'(1 << FLAG_OT);
    localparam logic [FLAG_W-1:0] FL_NONE = '0;

    typedef struct packed {
        t_cmd                      cmd;
        logic                      hw;
        logic [VOLT_W-1:0]         volt;
        logic [CURR_W-1:0]         curr;
        logic signed [TEMP_W-1:0]  temp;
    } t_sample;

    // Packed as on m_axis_tdata, highest field first
    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic               lamp;
        logic               shut;
        logic               fault;
        logic [FLAG_W-1:0]  flags;
    } t_res;

    typedef struct packed {
        t_sample smp;
        logic    typed;
        t_res    want;
    } t_row;

    // Directed items: sample, then typed flag, then {power, lamp, shut, fault, flags}
    localparam t_row DIRECTED [22] = '{
        // all zero after reset, voltage at its limit, then one above
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd0}, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}},
        '{'{CMD_TICK, 1'b0, 16'd15000, 16'd0, 12'sd0}, 1'b1,
          '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}},
        '{'{CMD_TICK, 1'b0, 16'd15001, 16'd0, 12'sd0}, 1'b1,
          '{32'd0, 1'b0, 1'b1, 1'b1, FL_OV}},
        // clean sample releases the fault
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd0}, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd11001, 12'sd0}, 1'b1,
          '{32'd0, 1'b0, 1'b1, 1'b1, FL_OC}},
        // hardware trip, then hardware trip with every field at its top
        '{'{CMD_TICK, 1'b1, 16'd0, 16'd0, 12'sd0}, 1'b1,
          '{32'd0, 1'b1, 1'b1, 1'b1, FL_OV | FL_OC}},
        '{'{CMD_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 12'sd2047}, 1'b1,
          '{32'd4294836225, 1'b1, 1'b1, 1'b1, FL_OV | FL_OC}},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd0}, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}},
        // power just under and just over its limit
        '{'{CMD_TICK, 1'b0, 16'd1000, 16'd10000, 12'sd0}, 1'b1,
          '{32'd10000000, 1'b0, 1'b0, 1'b0, FL_NONE}},
        '{'{CMD_TICK, 1'b0, 16'd1050, 16'd10001, 12'sd0}, 1'b1,
          '{32'd10501050, 1'b0, 1'b1, 1'b1, FL_OP}},
        // temperature trip, warn band, hysteresis hold, then clear
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd901}, 1'b1,
          '{32'd0, 1'b0, 1'b1, 1'b1, FL_OT}},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd900}, 1'b1,
          '{32'd0, 1'b0, 1'b0, 1'b1, FL_OT}},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd700}, 1'b1,
          '{32'd0, 1'b0, 1'b0, 1'b1, FL_OT}},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd650}, 1'b1,
          '{32'd0, 1'b0, 1'b0, 1'b1, FL_OT}},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd649}, 1'b1,
          '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sh800}, 1'b1,
          '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}},
        // ping ignores its sample fields
        '{'{CMD_PING, 1'b1, 16'hFFFF, 16'hFFFF, 12'sd2047}, 1'b1,
          '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}},
        '{'{CMD_TICK, 1'b1, 16'd0, 16'd0, 12'sd0}, 1'b1,
          '{32'd0, 1'b1, 1'b1, 1'b1, FL_OV | FL_OC}},
        '{'{CMD_PING, 1'b0, 16'd0, 16'd0, 12'sd0}, 1'b1,
          '{32'd0, 1'b1, 1'b0, 1'b1, FL_OV | FL_OC}},
        // software trip keeps the lamp and the later flags
        '{'{CMD_TICK, 1'b0, 16'd15001, 16'd11001, 12'sd2047}, 1'b1,
          '{32'd165026001, 1'b1, 1'b1, 1'b1, FL_OV | FL_OC}},
        '{'{CMD_TICK, 1'b0, 16'd12345, 16'd678, -12'sd550}, 1'b0, '0},
        '{'{CMD_TICK, 1'b0, 16'd0, 16'd0, 12'sd0}, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b0, FL_NONE}}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Model copy of the limits
    logic [VOLT_W-1:0]        lim_volt  = OV_LIMIT_RST;
    logic [CURR_W-1:0]        lim_curr  = OC_LIMIT_RST;
    logic [POWER_W-1:0]       lim_power = OP_LIMIT_RST;
    logic signed [TEMP_W-1:0] temp_trip = OT_TRIP_RST;
    logic signed [TEMP_W-1:0] temp_warn = OT_WARN_RST;
    logic [HYST_W-1:0]        temp_hyst = OT_HYST_RST;
    logic [TOUT_W-1:0]        link_tout = LINK_TOUT_RST;

    // Model copy of the protection state
    logic [FLAG_W-1:0]   prot_flags = '0;
    logic                fault_latched = 1'b0;
    logic                lamp_on = 1'b0;
    logic [AGE_BITS-1:0] tick_age = '0;

    t_res        expected_q[$];
    logic [31:0] phase_cfg [7];
    int          mismatches = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;
    int          ready_hold = 0;
    bit          src_idle_en = 1'b1;
    bit          snk_idle_en = 1'b1;

    load_protection_monitor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Judge one item, advance the protection state and return the result
    function automatic t_res judge_sample(input t_sample smp);
        t_res r;
        logic stop;
        int   clr_lvl;
        r = '0;
        if (smp.cmd == CMD_PING) begin
            tick_age = '0;
        end else begin
            r.power = POWER_W'(smp.volt) * POWER_W'(smp.curr);
            clr_lvl = int'(temp_warn) - int'(temp_hyst);
            if (tick_age != '1)
                tick_age = tick_age + 1'b1;
            stop = 1'b0;
            if (smp.hw) begin
                prot_flags[FLAG_OV] = 1'b1;
                prot_flags[FLAG_OC] = 1'b1;
                lamp_on = 1'b1;
                stop = 1'b1;
            end
            // first limit exceeded stops the chain; passed checks clear their flag
            if (!stop) begin
                prot_flags[FLAG_OV] = (smp.volt > lim_volt);
                stop = prot_flags[FLAG_OV];
            end
            if (!stop) begin
                prot_flags[FLAG_OC] = (smp.curr > lim_curr);
                stop = prot_flags[FLAG_OC];
            end
            if (!stop) begin
                prot_flags[FLAG_OP] = (r.power > lim_power);
                stop = prot_flags[FLAG_OP];
            end
            if (!stop) begin
                if (smp.temp > temp_trip) begin
                    prot_flags[FLAG_OT] = 1'b1;
                    stop = 1'b1;
                end else if (smp.temp > temp_warn) begin
                    prot_flags[FLAG_OT] = 1'b1;
                end else if (int'(smp.temp) < clr_lvl) begin
                    prot_flags[FLAG_OT] = 1'b0;
                end
            end
            if (stop) begin
                fault_latched = 1'b1;
                r.shut = 1'b1;
            end else begin
                prot_flags[FLAG_LINK] = (tick_age > link_tout);
                if (prot_flags == '0 && fault_latched) begin
                    fault_latched = 1'b0;
                    lamp_on = 1'b0;
                end
            end
        end
        r.flags = prot_flags;
        r.fault = fault_latched;
        r.lamp  = lamp_on;
        return r;
    endfunction

    // Random sample, biased toward the current limits
    function automatic t_sample draw_sample(input int ping_odds);
        t_sample     s;
        int          clr_lvl;
        logic [31:0] quot;
        s.cmd = (ping_odds != 0 && $urandom_range(1, ping_odds) == 1) ? CMD_PING : CMD_TICK;
        s.hw = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 3))
            0: s.volt = lim_volt + VOLT_W'($urandom_range(0, 4)) - VOLT_W'(2);
            1: s.volt = VOLT_W'($urandom);
            default: s.volt = VOLT_W'($urandom_range(0, lim_volt));
        endcase
        case ($urandom_range(0, 3))
            0: s.curr = lim_curr + CURR_W'($urandom_range(0, 4)) - CURR_W'(2);
            1: s.curr = CURR_W'($urandom);
            default: s.curr = CURR_W'($urandom_range(0, lim_curr));
        endcase
        // aim the product at the power limit now and then
        if (s.volt != '0 && $urandom_range(0, 3) == 0) begin
            quot = lim_power / s.volt;
            if (quot < 32'd65534)
                s.curr = CURR_W'(quot + $urandom_range(0, 2));
        end
        clr_lvl = int'(temp_warn) - int'(temp_hyst);
        case ($urandom_range(0, 5))
            0: s.temp = TEMP_W'(int'(temp_trip) + $urandom_range(0, 4) - 2);
            1: s.temp = TEMP_W'(int'(temp_warn) + $urandom_range(0, 4) - 2);
            2: s.temp = TEMP_W'(clr_lvl + $urandom_range(0, 4) - 2);
            3: s.temp = TEMP_W'($urandom);
            default: s.temp = TEMP_W'($urandom_range(0, 2050) - 550);
        endcase
        return s;
    endfunction

    // Offer one item, wait for it to be taken, queue its expected result
    task automatic push_item(input t_sample smp, input bit typed, input t_res want);
        t_res model_out;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, smp.temp, smp.curr, smp.volt, smp.hw};
        s_axis_tuser  <= smp.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        model_out = judge_sample(smp);
        expected_q.push_back(typed ? want : model_out);
    endtask

    // Drop valid, drain every pending result, then let the pipeline go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_OV_LIMIT:  lim_volt  = data[VOLT_W-1:0];
            REG_OC_LIMIT:  lim_curr  = data[CURR_W-1:0];
            REG_OP_LIMIT:  lim_power = data[POWER_W-1:0];
            REG_OT_TRIP:   temp_trip = data[TEMP_W-1:0];
            REG_OT_WARN:   temp_warn = data[TEMP_W-1:0];
            REG_OT_HYST:   temp_hyst = data[HYST_W-1:0];
            REG_LINK_TOUT: link_tout = data[TOUT_W-1:0];
            default: ;
        endcase
    endtask

    // Write all seven limits from phase_cfg while the block is idle
    task automatic program_limits();
        settle();
        for (int k = 0; k < 7; k++)
            write_reg(t_reg_idx'(k), phase_cfg[k]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int ping_odds, input bit idle_ok);
        src_idle_en = idle_ok && ($urandom_range(0, 3) != 0);
        snk_idle_en <= idle_ok && ($urandom_range(0, 3) != 0);
        repeat (count) push_item(draw_sample(ping_odds), 1'b0, '0);
    endtask

    // Result side: stall in random bursts
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_axis_tready <= (ready_hold == 1);
        end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(1, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("result %0d arrived with nothing expected: %h", results_seen, got);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (got.flags !== want.flags || got.fault !== want.fault ||
                    got.shut !== want.shut || got.lamp !== want.lamp ||
                    got.power !== want.power) begin
                    if (mismatches < 10)
                        $display({"result %0d want/got: flags %b/%b fault %b/%b off %b/%b ",
                                  "led %b/%b power %0d/%0d"}, results_seen,
                                 want.flags, got.flags, want.fault, got.fault,
                                 want.shut, got.shut, want.lamp, got.lamp,
                                 want.power, got.power);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // End the run when no channel has moved for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [11:0] trip_lvl;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table on reset limits
        for (int k = 0; k < $size(DIRECTED); k++)
            push_item(DIRECTED[k].smp, DIRECTED[k].typed, DIRECTED[k].want);

        // Extreme settings, including zero timeout and saturated timeout
        phase_cfg = '{32'd0, 32'd65535, 32'hFFFF_FFFF, 32'h0000_07FF, 32'h0000_0800,
                      32'd0, 32'd0};
        program_limits();
        run_phase(240, 10, 1'b1);
        phase_cfg = '{32'd65535, 32'd0, 32'd0, 32'h0000_0800, 32'h0000_07FF,
                      32'd1023, 32'd65535};
        program_limits();
        run_phase(240, 10, 1'b1);
        phase_cfg = '{32'd65535, 32'd65535, 32'hFFFF_FFFF, 32'd1500, 32'hFFFF_FDDA,
                      32'd1000, 32'd1};
        program_limits();
        run_phase(240, 4, 1'b1);

        // Random settings with short timeouts so the link flag comes and goes
        repeat (4) begin
            trip_lvl = 12'($urandom_range(0, 2050) - 550);
            phase_cfg[REG_OV_LIMIT]  = {16'($urandom), 16'($urandom_range(0, 20000))};
            phase_cfg[REG_OC_LIMIT]  = {16'($urandom), 16'($urandom_range(0, 15000))};
            phase_cfg[REG_OP_LIMIT]  = ($urandom_range(0, 1) != 0) ? $urandom
                                                                   : $urandom_range(0, 20000000);
            phase_cfg[REG_OT_TRIP]   = {20'($urandom), trip_lvl};
            phase_cfg[REG_OT_WARN]   = {20'($urandom), 12'(trip_lvl - $urandom_range(0, 600))};
            phase_cfg[REG_OT_HYST]   = {22'($urandom), 10'($urandom_range(0, 1000))};
            phase_cfg[REG_LINK_TOUT] = {16'($urandom), 16'($urandom_range(1, 40))};
            program_limits();
            run_phase(240, 30, 1'b1);
        end

        // Closing stretch at full rate on both sides, reset limits, short timeout
        phase_cfg = '{32'(OV_LIMIT_RST), 32'(OC_LIMIT_RST), OP_LIMIT_RST, 32'(OT_TRIP_RST),
                      32'(OT_WARN_RST), 32'(OT_HYST_RST), 32'd20};
        program_limits();
        run_phase(200, 25, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
